/* rtl/csvft_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csvft_pkg
// Shared types and constants of the CSV field tokenizer.
// ----------------------------------------------------------------------------
package csvft_pkg;

  // field widths
  localparam int unsigned ByteW = 8;
  localparam int unsigned RowW  = 16;
  localparam int unsigned ColW  = 10;

  // position limits, clipped to the counter widths
  localparam int unsigned MAX_ROWS    = 65535;
  localparam int unsigned MAX_COLUMNS = 1023;
  localparam int unsigned RowMaxVal   = (1 << RowW) - 1;
  localparam int unsigned ColMaxVal   = (1 << ColW) - 1;
  localparam logic [RowW-1:0] ROW_LIMIT =
    RowW'((MAX_ROWS < RowMaxVal) ? MAX_ROWS : RowMaxVal);
  localparam logic [ColW-1:0] COL_LIMIT =
    ColW'((MAX_COLUMNS < ColMaxVal) ? MAX_COLUMNS : ColMaxVal);

  // character codes
  localparam logic [ByteW-1:0] CH_CR    = 8'd13;
  localparam logic [ByteW-1:0] CH_LF    = 8'd10;
  localparam logic [ByteW-1:0] CH_QUOTE = 8'd34;
  localparam logic [ByteW-1:0] CH_COMMA = 8'd44;

  // separator after reset
  localparam logic [ByteW-1:0] SEP_RESET = CH_COMMA;

  // first row and column
  localparam logic [RowW-1:0] ROW_FIRST = RowW'(1);
  localparam logic [ColW-1:0] COL_FIRST = ColW'(1);

  // parser modes
  typedef enum logic [1:0] {
    MODE_START     = 2'd0,
    MODE_NORMAL    = 2'd1,
    MODE_QUOTED    = 2'd2,
    MODE_MAYBE_END = 2'd3
  } mode_e;

  // one result item
  typedef struct packed {
    logic             char_valid;
    logic [ByteW-1:0] out_char;
    logic             cell_done;
    logic [RowW-1:0]  cell_row;
    logic [ColW-1:0]  cell_column;
    logic             row_end;
    logic             parse_error;
  } result_t;

endpackage
`default_nettype wire

/* rtl/csvft_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csvft channels
// Valid/ready channels for text bytes and for tokenizer results.
// ----------------------------------------------------------------------------

// text byte channel
interface csvft_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink   (input valid, input text_byte, output ready);
endinterface

// result channel
interface csvft_result_if;
  logic        valid;
  logic        ready;
  logic        char_valid;
  logic [7:0]  out_char;
  logic        cell_done;
  logic [15:0] cell_row;
  logic [9:0]  cell_column;
  logic        row_end;
  logic        parse_error;

  modport source (output valid, output char_valid, output out_char, output cell_done,
                  output cell_row, output cell_column, output row_end,
                  output parse_error, input ready);
  modport sink   (input valid, input char_valid, input out_char, input cell_done,
                  input cell_row, input cell_column, input row_end,
                  input parse_error, output ready);
endinterface
`default_nettype wire

/* rtl/csv_field_tokenizer_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csv_field_tokenizer_core
// Byte-wide CSV tokenizer with quoted fields, row/column tracking and a
// sticky error flag.
// ----------------------------------------------------------------------------
// Takes one text byte per cycle and returns exactly one result per byte, in the
// cycle after the byte transfer. The parser state update is a single level
// of compare-and-select logic ahead of the result register, so a byte is
// accepted in every cycle in which the result register is empty or being
// drained; a stalled result holds back only the next byte. Rows saturate at
// 65535 and columns at 1023. A CR is swallowed (all flags zero) and the byte
// after it is parsed as is. After a parse error every byte still yields a
// result, with parse_error set and all other flags clear. The separator
// register may be written only while no result is pending.
// ----------------------------------------------------------------------------
module csv_field_tokenizer_core
  import csvft_pkg::*;
(
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             cfg_we_i,
  input  wire [ByteW-1:0] cfg_wdata_i,
  csvft_byte_if.sink      byte_i,
  csvft_result_if.source  result_o
);

  // state
  logic [ByteW-1:0] sep_q;
  mode_e            mode_q, mode_d;
  logic             after_cr_q, after_cr_d;
  logic             halted_q, halted_d;
  logic [RowW-1:0]  row_q, row_d, row_inc;
  logic [ColW-1:0]  col_q, col_d, col_inc;
  logic             res_valid_q;
  result_t          res_q, res_d;
  logic             in_xfer, out_xfer;
  logic [ByteW-1:0] b;
  logic             is_sep, is_lf, is_quote;

  // handshake: byte taken whenever the result register can be refilled
  assign out_xfer     = res_valid_q & result_o.ready;
  assign byte_i.ready = ~res_valid_q | result_o.ready;
  assign in_xfer      = byte_i.valid & byte_i.ready;

  // byte classification
  assign b        = byte_i.text_byte;
  assign is_sep   = (b == sep_q);
  assign is_lf    = (b == CH_LF);
  assign is_quote = (b == CH_QUOTE);

  // saturating position increments
  assign row_inc = (row_q < ROW_LIMIT) ? row_q + RowW'(1) : row_q;
  assign col_inc = (col_q < COL_LIMIT) ? col_q + ColW'(1) : col_q;

  // parser next state and result
  always_comb begin
    mode_d     = mode_q;
    after_cr_d = after_cr_q;
    halted_d   = halted_q;
    row_d      = row_q;
    col_d      = col_q;
    res_d.char_valid  = 1'b0;
    res_d.out_char    = '0;
    res_d.cell_done   = 1'b0;
    res_d.cell_row    = row_q;
    res_d.cell_column = col_q;
    res_d.row_end     = 1'b0;
    if (!halted_q) begin
      if ((b == CH_CR) && !after_cr_q) begin
        after_cr_d = 1'b1;
      end else begin
        after_cr_d = 1'b0;
        case (mode_q)
          MODE_START: begin
            if (is_quote) begin
              mode_d = MODE_QUOTED;
            end else if (is_sep) begin
              col_d = col_inc;
            end else if (is_lf) begin
              row_d = row_inc;
              col_d = COL_FIRST;
              res_d.row_end = 1'b1;
            end else begin
              res_d.char_valid = 1'b1;
              res_d.out_char   = b;
              mode_d = MODE_NORMAL;
            end
          end
          MODE_QUOTED: begin
            if (is_quote) begin
              mode_d = MODE_MAYBE_END;
            end else begin
              res_d.char_valid = 1'b1;
              res_d.out_char   = b;
            end
          end
          MODE_MAYBE_END: begin
            if (is_quote) begin
              res_d.char_valid = 1'b1;
              res_d.out_char   = b;
              mode_d = MODE_QUOTED;
            end else if (is_sep || is_lf) begin
              res_d.cell_done = 1'b1;
              mode_d = MODE_START;
              if (is_lf) begin
                row_d = row_inc;
                col_d = COL_FIRST;
                res_d.row_end = 1'b1;
              end else begin
                col_d = col_inc;
              end
            end else begin
              mode_d   = MODE_START;
              halted_d = 1'b1;
            end
          end
          MODE_NORMAL: begin
            if (is_sep || is_lf) begin
              res_d.cell_done = 1'b1;
              mode_d = MODE_START;
              if (is_lf) begin
                row_d = row_inc;
                col_d = COL_FIRST;
                res_d.row_end = 1'b1;
              end else begin
                col_d = col_inc;
              end
            end else begin
              res_d.char_valid = 1'b1;
              res_d.out_char   = b;
            end
          end
          default: begin
            mode_d = MODE_START;
          end
        endcase
      end
    end
    res_d.parse_error = halted_d;
  end

  // separator register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_q <= SEP_RESET;
    end else if (cfg_we_i) begin
      sep_q <= cfg_wdata_i;
    end
  end

  // parser state, updated on each byte transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_START;
      after_cr_q <= 1'b0;
      halted_q   <= 1'b0;
      row_q      <= ROW_FIRST;
      col_q      <= COL_FIRST;
    end else if (in_xfer) begin
      mode_q     <= mode_d;
      after_cr_q <= after_cr_d;
      halted_q   <= halted_d;
      row_q      <= row_d;
      col_q      <= col_d;
    end
  end

  // result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (in_xfer) begin
      res_valid_q <= 1'b1;
    end else if (out_xfer) begin
      res_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      res_q <= res_d;
    end
  end

  // output channel
  assign result_o.valid       = res_valid_q;
  assign result_o.char_valid  = res_q.char_valid;
  assign result_o.out_char    = res_q.out_char;
  assign result_o.cell_done   = res_q.cell_done;
  assign result_o.cell_row    = res_q.cell_row;
  assign result_o.cell_column = res_q.cell_column;
  assign result_o.row_end     = res_q.row_end;
  assign result_o.parse_error = res_q.parse_error;

`ifndef SYNTHESIS
  // error state never clears once set
  assert property (@(posedge clk_i) disable iff (!rst_ni) halted_q |=> halted_q)
    else $error("halted flag cleared");

  // a result never both appends a character and closes a cell
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> !(res_q.char_valid && res_q.cell_done))
    else $error("char and cell_done in one result");

  // an error result carries no other flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_q.parse_error) |->
      !(res_q.char_valid || res_q.cell_done || res_q.row_end))
    else $error("flags set alongside parse error");

  // a row end restarts the column count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && res_d.row_end) |=> (col_q == COL_FIRST))
    else $error("column not reset after row end");

  // positions stay one-based
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (row_q != '0) && (col_q != '0))
    else $error("row or column reached zero");
`endif

endmodule
`default_nettype wire
